// File: rtl/sorted_set_table_assert.svh
// Assertion macros for the sorted set table RTL, used by sst_dp.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// checked only while out of reset
`define SST_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SST_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/sst_pkg.sv
// Package for the sorted set table: sizes, request codes, control structs.
// No dependencies; used by every module of the block except sst_ram.
`timescale 1ns / 1ps
package sst_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OUT_W      = 16;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic load;
        logic probe_rd;
        logic probe_upd;
        logic decide;
        logic shift;
        logic finish;
        logic push;
    } t_sst_cmd;

    typedef struct packed {
        logic is_clear;
        logic search_done;
        logic go_shift;
        logic shift_busy;
        logic out_free;
    } t_sst_sts;

    function automatic logic [VALUE_BITS-1:0] f_entry(input logic [31:0] v);
        logic [95:0] w;
        w = {64'b0, v};
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [6:0] f_count(input logic [CNT_W-1:0] h);
        logic [CNT_W+6:0] w;
        w = {7'b0, h};
        return w[6:0];
    endfunction

endpackage

// File: rtl/sst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sst_ctrl.sv
// Controller for the sorted set table: sequences search, shift and reply.
// Depends on sst_pkg.
`timescale 1ns / 1ps
module sst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sst_pkg::t_sst_sts i_sts,
    output sst_pkg::t_sst_cmd o_cmd
);
    import sst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_FINISH,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RD;
                        r_ready <= 1'b0;
                    end
                end
                S_RD: begin
                    if (i_sts.is_clear || i_sts.search_done) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_RD;
                end
                S_DECIDE: begin
                    r_state <= i_sts.go_shift ? S_SHIFT : S_RESP;
                end
                S_SHIFT: begin
                    if (!i_sts.shift_busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.probe_rd  = (r_state == S_RD) && !i_sts.is_clear && !i_sts.search_done;
        o_cmd.probe_upd = (r_state == S_CMP);
        o_cmd.decide    = (r_state == S_DECIDE);
        o_cmd.shift     = (r_state == S_SHIFT);
        o_cmd.finish    = (r_state == S_FINISH);
        o_cmd.push      = (r_state == S_RESP) && i_sts.out_free;
    end

    assign o_in_ready = r_ready;
endmodule

// File: rtl/sst_dp.sv
// Datapath for the sorted set table: entry RAM, search bounds, shift pipe,
// count and result register. Depends on sst_pkg, sst_ram and the assert macros.
`timescale 1ns / 1ps
`include "sorted_set_table_assert.svh"
module sst_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sst_pkg::t_sst_cmd          i_cmd,
    output sst_pkg::t_sst_sts          o_sts,
    input  logic [1:0]                 i_op,
    input  logic [31:0]                i_value,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [sst_pkg::OUT_W-1:0]  o_out_data
);
    import sst_pkg::*;

    logic [1:0]            r_op;
    logic [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]      r_lo;
    logic [CNT_W-1:0]      r_hi;
    logic [CNT_W-1:0]      r_held;
    logic                  r_eq;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_rk;
    logic                  r_wv;
    logic [IDX_W-1:0]      r_wa;
    logic                  r_done;
    logic                  r_reject;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic [CNT_W-1:0]      w_mid;
    logic [CNT_W-1:0]      w_rk_up;
    logic [CNT_W-1:0]      w_rk_dn;
    logic                  w_is_ins;
    logic                  w_full;
    logic                  w_go_ins;
    logic                  w_go_era;
    logic                  w_shift_rd;
    logic                  w_re;
    logic [IDX_W-1:0]      w_raddr;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [VALUE_BITS-1:0] w_rdata;

    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rk_up    = r_rk + CNT_W'(1);
    assign w_rk_dn    = r_rk - CNT_W'(1);
    assign w_is_ins   = (r_op == OP_INSERT);
    assign w_full     = (r_held >= CNT_W'(CAPACITY));
    assign w_go_ins   = w_is_ins && !r_eq && !w_full;
    assign w_go_era   = (r_op == OP_ERASE) && r_eq;
    assign w_shift_rd = i_cmd.shift && (r_rem != '0);

    assign w_re    = i_cmd.probe_rd || w_shift_rd;
    assign w_raddr = i_cmd.probe_rd ? w_mid[IDX_W-1:0] : r_rk[IDX_W-1:0];
    assign w_we    = r_wv || (i_cmd.finish && w_is_ins);
    assign w_waddr = r_wv ? r_wa : r_lo[IDX_W-1:0];
    assign w_wdata = r_wv ? w_rdata : r_value;

    sst_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wv <= w_shift_rd;
            if (i_cmd.decide && (r_op == OP_CLEAR)) begin
                r_held <= '0;
            end else if (i_cmd.finish) begin
                r_held <= w_is_ins ? r_held + CNT_W'(1) : r_held - CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= f_entry(i_value);
            r_lo    <= '0;
            r_hi    <= r_held;
            r_eq    <= 1'b0;
        end
        if (i_cmd.probe_upd) begin
            if (w_rdata < r_value) begin
                r_lo <= w_mid + CNT_W'(1);
            end else begin
                r_hi <= w_mid;
                r_eq <= (w_rdata == r_value);
            end
        end
        if (i_cmd.decide) begin
            r_done   <= (r_op == OP_CLEAR) || ((r_op == OP_QUERY) && r_eq)
                        || w_go_ins || w_go_era;
            r_reject <= w_is_ins && !r_eq && w_full;
            if (w_go_ins) begin
                r_rem <= r_held - r_lo;
            end else if (w_go_era) begin
                r_rem <= r_held - r_lo - CNT_W'(1);
            end else begin
                r_rem <= '0;
            end
            r_rk <= w_is_ins ? r_held - CNT_W'(1) : r_lo + CNT_W'(1);
        end
        if (w_shift_rd) begin
            r_rem <= r_rem - CNT_W'(1);
            r_rk  <= w_is_ins ? w_rk_dn : w_rk_up;
            r_wa  <= w_is_ins ? w_rk_up[IDX_W-1:0] : w_rk_dn[IDX_W-1:0];
        end
        if (i_cmd.push) begin
            r_out_data <= {{(OUT_W - 9){1'b0}}, f_count(r_held), r_reject, r_done};
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.is_clear    = (r_op == OP_CLEAR);
        o_sts.search_done = !(r_lo < r_hi);
        o_sts.go_shift    = w_go_ins || w_go_era;
        o_sts.shift_busy  = (r_rem != '0) || r_wv;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `SST_ASSERT_ALWAYS(a_held_cap, (!i_rst_n) || (r_held <= CNT_W'(CAPACITY)), "held count over capacity")
    `SST_ASSERT(a_bounds, i_cmd.probe_rd |-> (r_lo < r_hi) && (r_hi <= r_held), "search bounds broken")
    `SST_ASSERT(a_ins_room, (i_cmd.finish && w_is_ins) |-> !w_full, "insert into full store")
    `SST_ASSERT(a_no_wr_search, (i_cmd.probe_rd || i_cmd.probe_upd) |-> !w_we, "write during search")
endmodule

// File: rtl/sorted_set_table.sv
// Top level of the sorted set table: stream ports, controller and datapath.
// Depends on sst_pkg, sst_ctrl, sst_dp.
//
// channel  | dir | tdata                         | tuser
// s_axis   | in  | [31:0] value                  | [1:0] op
// m_axis   | out | [0] done_res [1] full_reject  | none
//          |     | [8:2] count, [15:9] zero      |
//
// Each item runs a binary search over the RAM, one probe per step, then replies;
// insert or erase also shifts every entry above the found place by one, through
// the shift loop on the single RAM read port and single RAM write port.
// Reset (synchronous, active low) empties the set; entries need no clearing.
// A stalled result waits in the output register; the next item is taken
// meanwhile and its reply holds until the register frees.
`timescale 1ns / 1ps
module sorted_set_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] done_res, [1] full_reject, [8:2] count
);
    import sst_pkg::*;

    t_sst_cmd w_cmd;
    t_sst_sts w_sts;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );
endmodule

// File: dv/tb_sorted_set_table.sv
`timescale 1ns / 1ps
// Testbench for sorted_set_table: directed, fill-to-full, random, backpressure and
// steady-stream tests checked against an in-bench sorted set predictor.
// Depends on sst_pkg and the sorted_set_table RTL.
module tb_sorted_set_table;
    import sst_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 120;
    localparam int POOL_SIZE    = 80;
    localparam int HOLD_LEN     = 400;

    typedef struct packed {
        logic       done_res;
        logic       full_reject;
        logic [6:0] count;
    } t_set_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic [1:0]  s_axis_tuser;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [0] done_res, [1] full_reject, [8:2] count

    t_set_reply            reply_q[$];
    logic [VALUE_BITS-1:0] set_vals [CAPACITY];
    int                    set_size = 0;
    logic [31:0]           pool [POOL_SIZE];

    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    int hold_cycles = 0;
    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_changes   = 0;
    int n_rejects   = 0;
    int n_hits      = 0;
    int peak_size   = 0;
    int cycles      = 0;

    sorted_set_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, reply_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // sorted set predictor: lower-bound search, shift up on insert, down on erase
    function automatic t_set_reply set_apply(input logic [1:0] op, input logic [31:0] value);
        logic [VALUE_BITS-1:0] v;
        int                    lo;
        int                    hi;
        int                    mid;
        int                    k;
        bit                    found;
        t_set_reply            r;
        v = VALUE_BITS'(value);
        r = '0;
        if (op == OP_CLEAR) begin
            set_size   = 0;
            r.done_res = 1'b1;
        end else begin
            lo = 0;
            hi = set_size;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (set_vals[mid] < v) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            found = (lo < set_size) && (set_vals[lo] == v);
            case (op)
                OP_QUERY: begin
                    r.done_res = found;
                end
                OP_INSERT: begin
                    if (!found) begin
                        if (set_size >= CAPACITY) begin
                            r.full_reject = 1'b1;
                        end else begin
                            for (k = set_size; k > lo; k--) set_vals[k] = set_vals[k - 1];
                            set_vals[lo] = v;
                            set_size++;
                            r.done_res = 1'b1;
                        end
                    end
                end
                default: begin
                    if (found) begin
                        for (k = lo; k + 1 < set_size; k++) set_vals[k] = set_vals[k + 1];
                        set_size--;
                        r.done_res = 1'b1;
                    end
                end
            endcase
        end
        r.count = 7'(set_size);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [31:0] value);
        int         gap;
        t_set_reply r;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 2'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = set_apply(op, value);
        reply_q.push_back(r);
        n_items++;
        if (op != OP_QUERY && op != OP_CLEAR && r.done_res) n_changes++;
        if (op == OP_QUERY && r.done_res) n_hits++;
        if (r.full_reject) n_rejects++;
        if (set_size > peak_size) peak_size = set_size;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return OP_INSERT;
        if (r < 70) return OP_QUERY;
        if (r < 98) return OP_ERASE;
        return OP_CLEAR;
    endfunction

    // receiver ready: random stall bursts, plus a long hold when requested
    initial begin : rx_ready
        int burst;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (burst) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic note_fail(input string what, input logic [31:0] want, input logic [31:0] got);
        errors++;
        if (errors <= 10) begin
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     n_results, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : chk
        t_set_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (reply_q.size() == 0) begin
                note_fail("unexpected result", 32'd0, 32'(m_axis_tdata));
            end else begin
                want = reply_q.pop_front();
                if (m_axis_tdata[0] !== want.done_res)
                    note_fail("done_res", 32'(want.done_res), 32'(m_axis_tdata[0]));
                if (m_axis_tdata[1] !== want.full_reject)
                    note_fail("full_reject", 32'(want.full_reject), 32'(m_axis_tdata[1]));
                if (m_axis_tdata[8:2] !== want.count)
                    note_fail("count", 32'(want.count), 32'(m_axis_tdata[8:2]));
                if (m_axis_tdata[15:9] !== 7'd0)
                    note_fail("padding", 32'd0, 32'(m_axis_tdata[15:9]));
            end
        end
    end

    task automatic test_directed();
        send_item(OP_QUERY,  32'h0000_0000);   // empty set
        send_item(OP_ERASE,  32'h0000_0005);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);   // already present
        send_item(OP_QUERY,  32'h0000_0000);
        send_item(OP_QUERY,  32'hFFFF_FFFF);
        send_item(OP_QUERY,  32'h7FFF_FFFF);
        send_item(OP_ERASE,  32'h7FFF_FFFF);   // absent
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_QUERY,  32'h0000_0001);
        send_item(OP_ERASE,  32'h0000_0000);
        send_item(OP_ERASE,  32'hFFFF_FFFF);
        send_item(OP_ERASE,  32'h8000_0000);
        send_item(OP_CLEAR,  32'hFFFF_FFFF);
        send_item(OP_QUERY,  32'h0000_0001);   // stale entry must not hit
        send_item(OP_ERASE,  32'h0000_0001);
        send_item(OP_INSERT, 32'h0000_0001);
        send_item(OP_CLEAR,  32'h0000_0000);
        send_item(OP_QUERY,  32'h0000_0000);
    endtask

    task automatic test_fill();
        logic [31:0] kept;
        int          i;
        send_item(OP_CLEAR, $urandom);
        for (i = 0; i < CAPACITY; i++) begin
            kept = ($urandom & 32'hFFFF_FFC0) | 32'(i);
            send_item(OP_INSERT, kept);
        end
        send_item(OP_INSERT, $urandom);        // full: rejected
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, kept);            // full but present
        send_item(OP_QUERY, kept);
        send_item(OP_ERASE, kept);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'h0000_0001);   // full again
        send_item(OP_QUERY, 32'h0000_0000);
    endtask

    task automatic test_random(input int n);
        int i;
        for (i = 0; i < n; i++) send_item(pick_op(), pick_value());
    endtask

    task automatic test_backpressure();
        int i;
        hold_cycles = HOLD_LEN;
        for (i = 0; i < 12; i++) send_item(pick_op(), pick_value());
    endtask

    task automatic test_steady(input int n);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random(n);
    endtask

    initial begin : main
        int i;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h0000_0001;
        pool[3] = 32'h8000_0000;
        pool[4] = 32'h7FFF_FFFF;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill();
        test_random(340);
        test_backpressure();
        test_random(20);
        test_steady(60);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d replies checked: %0d changes, %0d query hits, %0d rejects",
                 n_items, n_results, n_changes, n_hits, n_rejects);
        $display("largest set %0d of %0d, %0d errors", peak_size, CAPACITY, errors);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
